>>> hdl/npms_pkg.sv
// Shared types and constants for the nearest point mode selector.
// Used by npms_cell and nearest_point_mode_selector; depends on nothing.

package npms_pkg;

   // Fixed widths of the transaction fields and the threshold register.
   localparam int FIELD_W      = 24;
   localparam int POLICY_W     = 4;
   localparam int THRESH_W     = 16;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd26;

   // Command codes of an input transaction.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Mode machine codes; the fourth code is unused and acts as the initial mode.
   localparam logic [1:0] MODE_INITIAL = 2'd0;
   localparam logic [1:0] MODE_NEW     = 2'd1;
   localparam logic [1:0] MODE_STABLE  = 2'd2;

   // Input transaction.
   typedef struct packed {
      logic               command;
      logic [FIELD_W-1:0] commit_rate;
      logic [FIELD_W-1:0] abort_rate;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic                use_default;
      logic [POLICY_W-1:0] policy_index;
      logic                empty_table_error;
   } rsp_type;

   // Control bits of the search token that walks down the cell row.
   typedef struct packed {
      logic valid;   // token present at this position
      logic have;    // a candidate has already been taken
   } tok_ctrl_type;

endpackage

>>> hdl/nearest_point_mode_selector.sv
// Top level of the nearest point mode selector: mode machine, baseline check
// and a row of npms_cell instances. Uses npms_pkg and npms_cell.
//
// Usage: req_valid/req_ready carry input transactions (req_type). A load
// transaction (command 0) stores a reference point in the next free cell
// and returns nothing; a load with a full table is dropped. A sample
// transaction (command 1) returns exactly one transaction on rsp_valid/rsp_ready
// (rsp_type). csr_wr_en writes the change threshold from csr_wr_data at once.
// A sample that needs no match is answered from the evaluation state into the
// output register (or the holding register), and the block takes no new
// transaction until it is back in idle. A sample in the new mode with a loaded
// table launches a search token down the cell row, one cell a cycle, and is
// answered once the token leaves the last cell; a load leaves the block idle.
// Reset is synchronous: mode initial, baseline and point count zero, threshold
// 26, no result pending. Stored points are not cleared and need no pass.
// When the receiver stalls, a finished result waits in the output register while
// one more transaction is taken; a second finished result waits in a holding
// register and input is not taken until the output register frees.

module nearest_point_mode_selector
   import npms_pkg::*;
#(
   parameter int MAX_POINTS = 16,
   parameter int RATE_BITS  = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [THRESH_W-1:0] csr_wr_data
);

   localparam int RATE_W = (RATE_BITS < FIELD_W) ? RATE_BITS : FIELD_W;
   localparam int DIST_W = 2 * RATE_W + 1;
   localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int CMP_W  = THRESH_W + RATE_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          mode_ff, mode_in;
   logic [RATE_W-1:0]   base_c_ff, base_c_in, base_a_ff, base_a_in;
   logic [IDX_W-1:0]    chosen_ff, chosen_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [THRESH_W-1:0] thresh_ff;
   logic [RATE_W-1:0]   smp_c_ff, smp_a_ff;
   logic                launch_ff, launch_in;
   rsp_type             rsp_ff, rsp_in, pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic              req_fire, load_fire, sample_fire, out_free;
   logic [RATE_W-1:0] req_c, req_a, diff_c;
   logic [CMP_W-1:0]  lhs, prod;
   logic              changed;
   logic              eval_scan, res_fire, scan_done;
   rsp_type           eval_res, res;

   tok_ctrl_type      tok_ctrl [0:MAX_POINTS];
   logic [DIST_W-1:0] tok_dist [0:MAX_POINTS];
   logic [IDX_W-1:0]  tok_idx  [0:MAX_POINTS];

   // Input handshake and masked rates.
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign load_fire   = req_fire && (req_data.command == CMD_LOAD);
   assign sample_fire = req_fire && (req_data.command == CMD_SAMPLE);
   assign req_c       = req_data.commit_rate[RATE_W-1:0];
   assign req_a       = req_data.abort_rate[RATE_W-1:0];
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Threshold register; its product with the baseline feeds the change test.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   assign prod = CMP_W'(thresh_ff) * CMP_W'(base_c_ff);

   // Sample holding register, read by every cell during evaluation and search.
   always_ff @(posedge clock) begin
      if (sample_fire) begin
         smp_c_ff <= req_c;
         smp_a_ff <= req_a;
      end
   end

   // Relative change test against the baseline commit rate.
   assign diff_c  = (smp_c_ff >= base_c_ff) ? smp_c_ff - base_c_ff : base_c_ff - smp_c_ff;
   assign lhs     = CMP_W'(diff_c) << 8;
   assign changed = (base_c_ff == '0) ? (smp_c_ff != '0) : (lhs > prod);

   // Row of cells; the search token enters at cell zero.
   assign tok_ctrl[0].valid = launch_ff;
   assign tok_ctrl[0].have  = 1'b0;
   assign tok_dist[0]       = '0;
   assign tok_idx[0]        = '0;

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      npms_cell #(
         .RATE_W (RATE_W),
         .IDX_W  (IDX_W),
         .CNT_W  (CNT_W),
         .INDEX  (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .load_en       (load_fire),
         .point_count   (count_ff),
         .point_commit  (req_c),
         .point_abort   (req_a),
         .sample_commit (smp_c_ff),
         .sample_abort  (smp_a_ff),
         .tok_in        (tok_ctrl[i]),
         .dist_in       (tok_dist[i]),
         .idx_in        (tok_idx[i]),
         .tok_out       (tok_ctrl[i+1]),
         .dist_out      (tok_dist[i+1]),
         .idx_out       (tok_idx[i+1])
      );
   end

   assign scan_done = tok_ctrl[MAX_POINTS].valid;

   // Mode machine decision for the held sample.
   always_comb begin
      mode_in   = mode_ff;
      base_c_in = base_c_ff;
      base_a_in = base_a_ff;
      chosen_in = chosen_ff;
      eval_scan = 1'b0;
      eval_res  = '0;
      if (state_ff == ST_EVAL) begin
         case (mode_ff)
            MODE_NEW: begin
               if (count_ff == '0) begin
                  eval_res.use_default       = 1'b1;
                  eval_res.empty_table_error = 1'b1;
               end else begin
                  eval_scan = 1'b1;
               end
            end
            MODE_STABLE: begin
               if ((base_c_ff == '0) && (base_a_ff == '0)) begin
                  base_c_in             = smp_c_ff;
                  base_a_in             = smp_a_ff;
                  eval_res.policy_index = POLICY_W'(chosen_ff);
               end else if (changed) begin
                  mode_in              = MODE_NEW;
                  base_c_in            = '0;
                  base_a_in            = '0;
                  eval_res.use_default = 1'b1;
               end else begin
                  eval_res.policy_index = POLICY_W'(chosen_ff);
               end
            end
            default: begin
               mode_in              = MODE_NEW;
               base_c_in            = '0;
               base_a_in            = '0;
               eval_res.use_default = 1'b1;
            end
         endcase
      end
      if (scan_done) begin
         mode_in   = MODE_STABLE;
         chosen_in = tok_idx[MAX_POINTS];
      end
   end

   // A finished result goes to the output register when it is free, otherwise
   // to the holding register.
   always_comb begin
      res          = '0;
      res_fire     = 1'b0;
      state_in     = state_ff;
      launch_in    = 1'b0;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (sample_fire) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (eval_scan) begin
               state_in  = ST_SCAN;
               launch_in = 1'b1;
            end else begin
               res_fire = 1'b1;
               res      = eval_res;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               res_fire            = 1'b1;
               res.policy_index    = POLICY_W'(tok_idx[MAX_POINTS]);
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (res_fire) begin
         if (out_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            pend_in  = res;
            state_in = ST_HOLD;
         end
      end
   end

   // Point count advances on each load that finds a free slot.
   always_comb begin
      count_in = count_ff;
      if (load_fire && (count_ff < CNT_W'(MAX_POINTS))) begin
         count_in = count_ff + 1'b1;
      end
   end

   // Control and mode state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_INITIAL;
         base_c_ff    <= '0;
         base_a_ff    <= '0;
         chosen_ff    <= '0;
         count_ff     <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         base_c_ff    <= base_c_in;
         base_a_ff    <= base_a_in;
         chosen_ff    <= chosen_in;
         count_ff     <= count_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // The point count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count exceeds table size");

   // A search token leaves the row only while a search is in progress.
   a_scan_state: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> (state_ff == ST_SCAN))
      else $error("search token outside a search");

   // An empty table answer always selects the default policy.
   a_err_default: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.empty_table_error) |-> rsp_ff.use_default)
      else $error("empty table error without default");

   // A new result appears only after a sample was being processed.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) != ST_IDLE))
      else $error("result without a sample transaction");

   // An accepted sample is always evaluated in the next cycle.
   a_sample_eval: assert property (@(posedge clock) disable iff (reset)
      sample_fire |=> (state_ff == ST_EVAL))
      else $error("sample transaction not evaluated");
`endif

endmodule

>>> hdl/npms_cell.sv
// One cell of the reference point row: stores a point, squares its distance
// to the held sample and updates the passing best-match token. Uses npms_pkg.

module npms_cell
   import npms_pkg::*;
#(
   parameter int RATE_W = 24,
   parameter int IDX_W  = 4,
   parameter int CNT_W  = 5,
   parameter int INDEX  = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_en,
   input  logic [CNT_W-1:0]  point_count,
   input  logic [RATE_W-1:0] point_commit,
   input  logic [RATE_W-1:0] point_abort,
   input  logic [RATE_W-1:0] sample_commit,
   input  logic [RATE_W-1:0] sample_abort,
   input  tok_ctrl_type      tok_in,
   input  logic [2*RATE_W:0] dist_in,
   input  logic [IDX_W-1:0]  idx_in,
   output tok_ctrl_type      tok_out,
   output logic [2*RATE_W:0] dist_out,
   output logic [IDX_W-1:0]  idx_out
);

   localparam int SQ_W   = 2 * RATE_W;
   localparam int DIST_W = SQ_W + 1;

   logic [RATE_W-1:0] commit_ff, abort_ff;
   logic [RATE_W-1:0] diff_c, diff_a;
   logic [SQ_W-1:0]   sq_c_in, sq_a_in, sq_c_ff, sq_a_ff;
   logic [DIST_W-1:0] dist_sum;
   logic              active, wr_en, take;
   tok_ctrl_type      tok_in_next, tok_ff;
   logic [DIST_W-1:0] dist_in_next, dist_ff;
   logic [IDX_W-1:0]  idx_in_next, idx_ff;

   // This cell holds the next free table slot when the count equals its index.
   assign wr_en  = load_en && (point_count == CNT_W'(INDEX));
   assign active = point_count > CNT_W'(INDEX);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         commit_ff <= point_commit;
         abort_ff  <= point_abort;
      end
   end

   // Squared component distances, registered ahead of the sum and compare.
   assign diff_c  = (sample_commit >= commit_ff) ? sample_commit - commit_ff
                                                 : commit_ff - sample_commit;
   assign diff_a  = (sample_abort >= abort_ff) ? sample_abort - abort_ff
                                               : abort_ff - sample_abort;
   assign sq_c_in = SQ_W'(diff_c) * SQ_W'(diff_c);
   assign sq_a_in = SQ_W'(diff_a) * SQ_W'(diff_a);

   always_ff @(posedge clock) begin
      sq_c_ff <= sq_c_in;
      sq_a_ff <= sq_a_in;
   end

   // Take the token's place when this point is strictly nearer, so the
   // earliest entry wins a tie.
   assign dist_sum = DIST_W'(sq_c_ff) + DIST_W'(sq_a_ff);
   assign take = tok_in.valid && active && (!tok_in.have || (dist_sum < dist_in));

   always_comb begin
      tok_in_next.valid = tok_in.valid;
      tok_in_next.have  = tok_in.have || (tok_in.valid && active);
      dist_in_next      = take ? dist_sum : dist_in;
      idx_in_next       = take ? IDX_W'(INDEX) : idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in_next;
      idx_ff  <= idx_in_next;
   end

   assign tok_out  = tok_ff;
   assign dist_out = dist_ff;
   assign idx_out  = idx_ff;

endmodule
